// ----- src/dism_pkg.sv -----
package dism_pkg;

  localparam int VAL_W = 31;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_EXT     = 3'd1;
  localparam logic [2:0] ST_MERGE   = 3'd2;
  localparam logic [2:0] ST_PRESENT = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t lo;
    val_t hi;
  } entry_t;

  typedef struct packed {
    logic lo_gt_v;
    logic v_le_hi;
    logic hi_adj;
    logic lo_adj;
  } cmp_t;

endpackage

// ----- src/dism_cmp.sv -----
module dism_cmp
  import dism_pkg::*;
(
  input  val_t   value,
  input  entry_t ent,
  output cmp_t   flags
);

  logic [VAL_W:0] v_ext;
  logic [VAL_W:0] lo_ext;
  logic [VAL_W:0] hi_ext;

  // one bit wider so the +1 never wraps
  assign v_ext  = {1'b0, value};
  assign lo_ext = {1'b0, ent.lo};
  assign hi_ext = {1'b0, ent.hi};

  assign flags.lo_gt_v = ent.lo > value;
  assign flags.v_le_hi = value <= ent.hi;
  assign flags.hi_adj  = (hi_ext + (VAL_W+1)'(1)) == v_ext;
  assign flags.lo_adj  = lo_ext == (v_ext + (VAL_W+1)'(1));

endmodule

// ----- src/disjoint_interval_set_merge_top.sv -----
// Sorted table of up to MAX_INTERVALS disjoint closed intervals, held in a
// one-read, one-write memory with registered read data and walked by a
// sequencer around a single compare unit. An insert request scans the table
// from the bottom, reading and checking each interval in turn until it meets
// one whose low end exceeds the value or the end of the table, then takes a
// decide step; a merge then moves every interval above the merge point down
// one place and a new interval moves every interval above it up one place,
// with one read and one write per moved interval. A dump request reads the
// intervals in turn and shows each as a result that waits for out_ready. One
// request is worked on at a time: in_ready is high only while the block idles,
// and it returns the cycle after the last result is taken.
module disjoint_interval_set_merge_top
  import dism_pkg::*;
#(
  parameter int MAX_INTERVALS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [2:0]       out_status,
  output logic [VAL_W-1:0] out_interval_low,
  output logic [VAL_W-1:0] out_interval_high,
  output logic [5:0]       out_interval_count,
  output logic             out_empty_res,
  output logic             out_last
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SHD_RD,
    S_SHD_WR,
    S_SHU_RD,
    S_SHU_WR,
    S_DUMP_RD,
    S_DUMP_LD,
    S_OUT
  } state_t;

  state_t  state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] count_r, count_nxt;
  val_t    val_r, val_nxt;
  entry_t  prev_r, prev_nxt;
  entry_t  next_r, next_nxt;
  logic    prev_in_r, prev_in_nxt;
  logic    prev_adj_r, prev_adj_nxt;
  logic    next_adj_r, next_adj_nxt;

  logic    out_valid_r, out_valid_nxt;
  logic    out_kind_r, out_kind_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  val_t    out_lo_r, out_lo_nxt;
  val_t    out_hi_r, out_hi_nxt;
  logic    out_empty_r, out_empty_nxt;
  logic    out_last_r, out_last_nxt;

  entry_t  mem [MAX_INTERVALS];
  entry_t  rd_q_r;
  logic    mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t  mem_wdata;

  logic [CW-1:0] idx_m1;
  logic [CW-1:0] pos_m1;
  cmp_t    flags;

  assign idx_m1 = idx_r - CW'(1);
  assign pos_m1 = pos_r - CW'(1);

  dism_cmp u_cmp (
    .value (val_r),
    .ent   (rd_q_r),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    val_nxt        = val_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    prev_in_nxt    = prev_in_r;
    prev_adj_nxt   = prev_adj_r;
    next_adj_nxt   = next_adj_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_lo_nxt     = out_lo_r;
    out_hi_nxt     = out_hi_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_raddr      = idx_r[AW-1:0];
    mem_wdata      = rd_q_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt      = in_value;
          idx_nxt      = '0;
          prev_in_nxt  = 1'b0;
          prev_adj_nxt = 1'b0;
          next_adj_nxt = 1'b0;
          if (in_cmd == CMD_DUMP) begin
            if (count_r == '0) begin
              out_kind_nxt   = KIND_DUMP;
              out_status_nxt = ST_NEW;
              out_lo_nxt     = '0;
              out_hi_nxt     = '0;
              out_empty_nxt  = 1'b1;
              out_last_nxt   = 1'b1;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_OUT;
            end else begin
              state_nxt = S_DUMP_RD;
            end
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          pos_nxt   = idx_r;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (flags.lo_gt_v) begin
          pos_nxt      = idx_r;
          next_nxt     = rd_q_r;
          next_adj_nxt = flags.lo_adj;
          state_nxt    = S_DECIDE;
        end else begin
          prev_nxt     = rd_q_r;
          prev_in_nxt  = flags.v_le_hi;
          prev_adj_nxt = flags.hi_adj;
          idx_nxt      = idx_r + CW'(1);
          state_nxt    = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        out_kind_nxt  = KIND_STATUS;
        out_empty_nxt = 1'b0;
        out_last_nxt  = 1'b1;
        if (prev_in_r) begin
          out_status_nxt = ST_PRESENT;
          out_lo_nxt     = prev_r.lo;
          out_hi_nxt     = prev_r.hi;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end else if (prev_adj_r && next_adj_r) begin
          mem_we         = 1'b1;
          mem_waddr      = pos_m1[AW-1:0];
          mem_wdata      = '{lo: prev_r.lo, hi: next_r.hi};
          out_status_nxt = ST_MERGE;
          out_lo_nxt     = prev_r.lo;
          out_hi_nxt     = next_r.hi;
          idx_nxt        = pos_r + CW'(1);
          state_nxt      = S_SHD_RD;
        end else if (prev_adj_r) begin
          mem_we         = 1'b1;
          mem_waddr      = pos_m1[AW-1:0];
          mem_wdata      = '{lo: prev_r.lo, hi: val_r};
          out_status_nxt = ST_EXT;
          out_lo_nxt     = prev_r.lo;
          out_hi_nxt     = val_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end else if (next_adj_r) begin
          mem_we         = 1'b1;
          mem_waddr      = pos_r[AW-1:0];
          mem_wdata      = '{lo: val_r, hi: next_r.hi};
          out_status_nxt = ST_EXT;
          out_lo_nxt     = val_r;
          out_hi_nxt     = next_r.hi;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end else if (count_r == CW'(MAX_INTERVALS)) begin
          out_status_nxt = ST_FULL;
          out_lo_nxt     = '0;
          out_hi_nxt     = '0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          out_status_nxt = ST_NEW;
          out_lo_nxt     = val_r;
          out_hi_nxt     = val_r;
          idx_nxt        = count_r;
          state_nxt      = S_SHU_RD;
        end
      end
      S_SHD_RD: begin
        if (idx_r == count_r) begin
          count_nxt     = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_SHD_WR;
        end
      end
      S_SHD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_m1[AW-1:0];
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SHD_RD;
      end
      S_SHU_RD: begin
        mem_raddr = idx_m1[AW-1:0];
        if (idx_r == pos_r) begin
          mem_we        = 1'b1;
          mem_waddr     = pos_r[AW-1:0];
          mem_wdata     = '{lo: val_r, hi: val_r};
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_SHU_WR;
        end
      end
      S_SHU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        idx_nxt   = idx_m1;
        state_nxt = S_SHU_RD;
      end
      S_DUMP_RD: begin
        state_nxt = S_DUMP_LD;
      end
      S_DUMP_LD: begin
        out_kind_nxt   = KIND_DUMP;
        out_status_nxt = ST_NEW;
        out_lo_nxt     = rd_q_r.lo;
        out_hi_nxt     = rd_q_r.hi;
        out_empty_nxt  = 1'b0;
        out_last_nxt   = (idx_r + CW'(1)) == count_r;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    prev_in_r    <= prev_in_nxt;
    prev_adj_r   <= prev_adj_nxt;
    next_adj_r   <= next_adj_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_lo_r     <= out_lo_nxt;
    out_hi_r     <= out_hi_nxt;
    out_empty_r  <= out_empty_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_status         = out_status_r;
  assign out_interval_low   = out_lo_r;
  assign out_interval_high  = out_hi_r;
  assign out_interval_count = 6'(count_r);
  assign out_empty_res      = out_empty_r;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_INTERVALS))
    else $error("interval count above table depth");

  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT)
    else $error("result shown outside output state");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW+1)'(mem_waddr) <= (CW+1)'(count_r))
    else $error("table write beyond stored intervals");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_SHD_RD && state_r != S_SHU_RD |=> $stable(count_r))
    else $error("interval count changed outside a shift step");
`endif

endmodule
